// ===== design/swm_pkg.sv =====
// Shared types and constants for the sliding window median alert block.
package swm_pkg;

  localparam int CFG_BITS   = 9;
  localparam int COUNT_BITS = 32;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  // Register index of window_length (byte address 4*index)
  localparam logic [0:0] REG_WINDOW_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MED_HI_W,
    ST_MED_LO_W,
    ST_OLD_W,
    ST_RESULT,
    ST_REM_RD,
    ST_REM_CHK,
    ST_INS_RD,
    ST_INS_CHK
  } swm_state_t;

endpackage

// ===== design/swm_if.sv =====
// Valid/ready channel interfaces for samples and results.
interface swm_in_if #(parameter int SAMPLE_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swm_out_if #(parameter int SAMPLE_BITS = 16);
  logic                 valid;
  logic                 ready;
  logic                 alert;
  logic [SAMPLE_BITS:0] twice_median;
  logic [31:0]          alert_count;
  modport source (output valid, output alert, output twice_median, output alert_count,
                  input ready);
  modport sink   (input valid, input alert, input twice_median, input alert_count,
                  output ready);
endinterface

// ===== design/swm_ram.sv =====
// Simple dual-port synchronous memory, one write and one registered read per cycle.
module swm_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sliding_window_median_alert.sv =====
// Sliding window median alert: ring and sorted window in memory, shifted one entry per step.
// A filling sample is written to the ring, then sorted in by moving larger entries up one at a time.
// A full-window sample (L window): the median entries are read (one for odd L, two for even L), the
// oldest sample is swapped for it in the ring, the result is registered once the output is free,
// then the oldest is removed and the new sample inserted, moving entries through the sorted read port.
// One result register; the next sample is accepted while a result waits.
// Reset (synchronous, rst_n low): window length 1, window empty, alert count 0.
module sliding_window_median_alert
  import swm_pkg::*;
#(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  swm_in_if.sink                in_chan,
  swm_out_if.source             out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [PADDR_BITS-1:0] cfg_paddr,
  input  logic [PDATA_BITS-1:0] cfg_pwdata,
  output logic [PDATA_BITS-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int SW = SAMPLE_BITS;

  swm_state_t state_r, state_nxt;

  logic [CFG_BITS-1:0]   wl_r;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [AW-1:0]         optr_r, optr_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  found_r, found_nxt;
  logic [SW-1:0]         smp_r, smp_nxt;
  logic [SW-1:0]         old_r, old_nxt;
  logic [SW-1:0]         hi_r, hi_nxt;
  logic [SW:0]           med2_r, med2_nxt;
  logic [COUNT_BITS-1:0] alerts_r, alerts_nxt;
  logic                  ov_r, ov_nxt;
  logic                  oalert_r, oalert_nxt;
  logic [SW:0]           omed_r, omed_nxt;

  logic [CW-1:0] len;
  logic [AW-1:0] optr_eff;
  logic          cfg_wr;
  logic          in_acc;
  logic          res_ok;
  logic          alert_now;

  logic          s_we, r_we;
  logic [AW-1:0] s_waddr, s_raddr, r_waddr, r_raddr;
  logic [SW-1:0] s_wdata, s_rdata, r_wdata, r_rdata;

  swm_ram #(.DEPTH(WINDOW_MAX), .WIDTH(SW), .AW(AW)) u_sorted (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  swm_ram #(.DEPTH(WINDOW_MAX), .WIDTH(SW), .AW(AW)) u_ring (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  // Config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[PADDR_BITS-1] == REG_WINDOW_LENGTH);
  assign cfg_prdata = (cfg_paddr[PADDR_BITS-1] == REG_WINDOW_LENGTH) ?
                      PDATA_BITS'(wl_r) : '0;

  // Effective window length: zero acts as one, clamp at capacity
  always_comb begin
    if (wl_r == '0) begin
      len = CW'(1);
    end else if (32'(wl_r) > 32'(WINDOW_MAX)) begin
      len = CW'(WINDOW_MAX);
    end else begin
      len = CW'(wl_r);
    end
  end

  assign optr_eff  = (CW'(optr_r) >= len) ? '0 : optr_r;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc    = in_chan.valid && in_chan.ready;
  assign res_ok    = !ov_r || out_chan.ready;
  assign alert_now = (med2_r <= {1'b0, smp_r});

  assign out_chan.valid        = ov_r;
  assign out_chan.alert        = oalert_r;
  assign out_chan.twice_median = omed_r;
  assign out_chan.alert_count  = alerts_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (fill_r < len) ? ST_INS_RD : ST_MED_HI_W;
        end
      end
      ST_MED_HI_W: state_nxt = len[0] ? ST_OLD_W : ST_MED_LO_W;
      ST_MED_LO_W: state_nxt = ST_OLD_W;
      ST_OLD_W:    state_nxt = ST_RESULT;
      ST_RESULT:   state_nxt = res_ok ? ST_REM_RD : ST_RESULT;
      ST_REM_RD:   state_nxt = ST_REM_CHK;
      ST_REM_CHK:  state_nxt = (cnt_r + CW'(1) == len) ? ST_INS_RD : ST_REM_RD;
      ST_INS_RD:   state_nxt = (cnt_r == '0) ? ST_IDLE : ST_INS_CHK;
      ST_INS_CHK:  state_nxt = (s_rdata > smp_r) ? ST_INS_RD : ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    fill_nxt   = fill_r;
    optr_nxt   = optr_r;
    cnt_nxt    = cnt_r;
    found_nxt  = found_r;
    smp_nxt    = smp_r;
    old_nxt    = old_r;
    hi_nxt     = hi_r;
    med2_nxt   = med2_r;
    alerts_nxt = alerts_r;
    ov_nxt     = ov_r && !out_chan.ready;
    oalert_nxt = oalert_r;
    omed_nxt   = omed_r;
    s_we = 1'b0; s_waddr = '0; s_wdata = smp_r; s_raddr = '0;
    r_we = 1'b0; r_waddr = '0; r_wdata = smp_r; r_raddr = optr_eff;
    case (state_r)
      ST_IDLE: begin
        s_raddr = AW'(len >> 1);
        if (in_acc) begin
          smp_nxt = in_chan.sample;
          if (fill_r < len) begin
            // Filling: store in ring, then sort into place
            r_we     = 1'b1;
            r_waddr  = fill_r[AW-1:0];
            r_wdata  = in_chan.sample;
            cnt_nxt  = fill_r;
            fill_nxt = fill_r + CW'(1);
          end
        end
      end
      ST_MED_HI_W: begin
        hi_nxt   = s_rdata;
        med2_nxt = {s_rdata, 1'b0};
        s_raddr  = AW'((len >> 1) - CW'(1));
      end
      ST_MED_LO_W: begin
        med2_nxt = {1'b0, hi_r} + {1'b0, s_rdata};
      end
      ST_OLD_W: begin
        // Oldest sample out, new sample into its ring slot
        old_nxt  = r_rdata;
        r_we     = 1'b1;
        r_waddr  = optr_eff;
        optr_nxt = (CW'(optr_eff) + CW'(1) >= len) ? '0 : optr_eff + AW'(1);
      end
      ST_RESULT: begin
        if (res_ok) begin
          ov_nxt     = 1'b1;
          oalert_nxt = alert_now;
          omed_nxt   = med2_r;
          if (alert_now && alerts_r != '1) begin
            alerts_nxt = alerts_r + COUNT_BITS'(1);
          end
          cnt_nxt   = '0;
          found_nxt = 1'b0;
        end
      end
      ST_REM_RD: begin
        s_raddr = cnt_r[AW-1:0];
      end
      ST_REM_CHK: begin
        // Shift entries after the removed one down by one
        if (found_r) begin
          s_we    = 1'b1;
          s_waddr = AW'(cnt_r - CW'(1));
          s_wdata = s_rdata;
        end else if (s_rdata == old_r) begin
          found_nxt = 1'b1;
        end
        cnt_nxt = (cnt_r + CW'(1) == len) ? len - CW'(1) : cnt_r + CW'(1);
      end
      ST_INS_RD: begin
        s_raddr = AW'(cnt_r - CW'(1));
        if (cnt_r == '0) begin
          s_we    = 1'b1;
          s_waddr = '0;
        end
      end
      ST_INS_CHK: begin
        // Move larger entries up until the slot for the new sample is found
        s_we    = 1'b1;
        s_waddr = cnt_r[AW-1:0];
        if (s_rdata > smp_r) begin
          s_wdata = s_rdata;
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wl_r     <= CFG_BITS'(1);
      fill_r   <= '0;
      optr_r   <= '0;
      alerts_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      alerts_r <= alerts_nxt;
      ov_r     <= ov_nxt;
      if (cfg_wr) begin
        wl_r   <= cfg_pwdata[CFG_BITS-1:0];
        fill_r <= '0;
        optr_r <= '0;
      end else begin
        fill_r <= fill_nxt;
        optr_r <= optr_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    found_r  <= found_nxt;
    smp_r    <= smp_nxt;
    old_r    <= old_nxt;
    hi_r     <= hi_nxt;
    med2_r   <= med2_nxt;
    oalert_r <= oalert_nxt;
    omed_r   <= omed_nxt;
  end

endmodule

// ===== tb/sv/swm_median_checker.sv =====
// Checker for the sliding window median alert block: predicts each result and compares.
`timescale 1ns / 100ps

module swm_median_checker
  import swm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  swm_in_if                     in_mon,
  swm_out_if                    out_mon,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [PADDR_BITS-1:0] cfg_paddr,
  input  logic [PDATA_BITS-1:0] cfg_pwdata,
  output int                    mismatch_count,
  output int                    results_pending
);

  localparam int DEPTH = 256;

  typedef struct packed {
    logic        alert;
    logic [16:0] twice_median;
    logic [31:0] alert_count;
  } median_result_t;

  // Predictor state
  logic [CFG_BITS-1:0] window_len;
  logic [15:0]         ring_q [DEPTH];
  logic [15:0]         ordered [DEPTH];
  int                  held;
  int                  oldest_slot;
  logic [31:0]         alert_total;
  median_result_t      expected_results [$];

  assign results_pending = expected_results.size();

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Insert into the ascending list ordered[0..count-1]
  task automatic ordered_insert(input int count, input logic [15:0] v);
    int pos;
    pos = count;
    while (pos > 0 && ordered[pos-1] > v) begin
      ordered[pos] = ordered[pos-1];
      pos--;
    end
    ordered[pos] = v;
  endtask

  // Drop the first entry equal to v
  task automatic ordered_remove(input int count, input logic [15:0] v);
    int pos;
    pos = 0;
    while (pos < count && ordered[pos] != v) pos++;
    if (pos < count) begin
      for (int k = pos; k + 1 < count; k++) ordered[k] = ordered[k+1];
    end
  endtask

  task automatic predict_sample(input logic [15:0] s);
    int             len;
    logic [16:0]    med2;
    median_result_t r;
    len = (window_len == 0) ? 1 : ((window_len > DEPTH) ? DEPTH : int'(window_len));
    // window still filling: store only
    if (held < len) begin
      ring_q[held] = s;
      ordered_insert(held, s);
      held++;
    end else begin
      if (len % 2 == 1) med2 = {ordered[len/2], 1'b0};
      else med2 = {1'b0, ordered[len/2-1]} + {1'b0, ordered[len/2]};
      r.alert = (med2 <= {1'b0, s});
      if (r.alert && alert_total != 32'hFFFF_FFFF) alert_total++;
      r.twice_median = med2;
      r.alert_count  = alert_total;
      expected_results.push_back(r);
      if (oldest_slot >= len) oldest_slot = 0;
      ordered_remove(len, ring_q[oldest_slot]);
      ordered_insert(len - 1, s);
      ring_q[oldest_slot] = s;
      oldest_slot++;
      if (oldest_slot >= len) oldest_slot = 0;
    end
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin
    median_result_t exp_r;
    if (!rst_n) begin
      window_len  = 1;
      held        = 0;
      oldest_slot = 0;
      alert_total = 0;
      expected_results.delete();
    end else begin
      // register write
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          (cfg_paddr >> 2) == REG_WINDOW_LENGTH) begin
        window_len  = cfg_pwdata[CFG_BITS-1:0];
        held        = 0;
        oldest_slot = 0;
      end
      // result transaction: compare with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_r = expected_results.pop_front();
          if (out_mon.alert !== exp_r.alert)
            report_mismatch($sformatf("alert got %b exp %b", out_mon.alert, exp_r.alert));
          if (out_mon.twice_median !== exp_r.twice_median)
            report_mismatch($sformatf("twice_median got %0d exp %0d",
                                      out_mon.twice_median, exp_r.twice_median));
          if (out_mon.alert_count !== exp_r.alert_count)
            report_mismatch($sformatf("alert_count got %0d exp %0d",
                                      out_mon.alert_count, exp_r.alert_count));
        end
      end
      // sample transaction
      if (in_mon.valid && in_mon.ready) predict_sample(in_mon.sample);
    end
  end

endmodule

// ===== tb/sv/tb_sliding_window_median_alert.sv =====
// Testbench top for the sliding window median alert block: stimulus and verdict.
`timescale 1ns / 100ps

module tb_sliding_window_median_alert;
  import swm_pkg::*;

  // Drain time before a register write or the verdict: worst busy time of a full window
  localparam int DRAIN_CYCLES = 1200;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [PADDR_BITS-1:0] cfg_paddr;
  logic [PDATA_BITS-1:0] cfg_pwdata;
  logic [PDATA_BITS-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    mismatch_count;
  int                    results_pending;
  int                    send_idle_pct;
  int                    recv_stall_pct;

  swm_in_if  in_if ();
  swm_out_if out_if ();

  sliding_window_median_alert dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_if),
    .out_chan   (out_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  swm_median_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_pready     (cfg_pready),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .mismatch_count (mismatch_count),
    .results_pending(results_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Receiver stalls
  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic cfg_write(input logic [PADDR_BITS-1:0] addr, input logic [PDATA_BITS-1:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Wait for every expected result, then for the block to finish its remaining window updates
  task automatic wait_drained();
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Valid stays high between back-to-back transactions
  task automatic send_sample(input logic [15:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= v;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(4))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(300));
      2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(65535) >> $urandom_range(15));
    endcase
  endfunction

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  // Timeout
  initial begin
    #(12.0 * 6_000_000);
    $display("sliding_window_median_alert regression: fail");
    $finish;
  end

  initial begin
    int          lens [12];
    int          counts [12];
    logic [15:0] directed [20];
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    set_idling(0);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: window of one after reset, field extremes, ties, twice median overflow
    directed = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h8000,
                 16'h7FFF, 16'h0001, 16'h0002, 16'h0004, 16'h0003, 16'hAAAA, 16'h5555,
                 16'h5555, 16'hAAAB, 16'h0000, 16'h0001, 16'h0001, 16'hFFFE};
    foreach (directed[i]) send_sample(directed[i]);
    @(posedge clk);
    in_if.valid <= 1'b0;
    wait_drained();
    // Write to an unmapped register: window must keep going
    cfg_write(3'd4, 32'h0000_0005);
    send_sample(16'd10);
    send_sample(16'd25);
    @(posedge clk);
    in_if.valid <= 1'b0;
    wait_drained();

    // Phases: zero acts as one and oversized lengths clamp, mostly small windows
    lens   = '{0, 2, 3, 4, 5, 6, 8, 16, 33, 511, 7, 1};
    counts = '{60, 100, 100, 100, 100, 100, 100, 120, 100, 290, 120, 60};
    foreach (lens[p]) begin
      cfg_write(PADDR_BITS'(int'(REG_WINDOW_LENGTH) * 4), PDATA_BITS'(lens[p]));
      set_idling(p);
      for (int n = 0; n < counts[p]; n++) begin
        // hold off once until the result queue is empty
        if (p == 4 && n == counts[p] / 2) begin
          @(posedge clk);
          in_if.valid <= 1'b0;
          while (results_pending != 0) @(posedge clk);
        end
        send_sample(pick_sample());
      end
      @(posedge clk);
      in_if.valid <= 1'b0;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("sliding_window_median_alert regression: pass");
    end else begin
      $display("sliding_window_median_alert regression: fail");
    end
    $finish;
  end

endmodule

// ===== sliding_window_median_alert.f =====
design/swm_pkg.sv
design/swm_if.sv
design/swm_ram.sv
design/sliding_window_median_alert.sv
tb/sv/swm_median_checker.sv
tb/sv/tb_sliding_window_median_alert.sv
